// ===== sv/job_status_edge_tracker_assert.svh =====
// Assertion macros shared by the job status edge tracker.
`ifndef JOB_STATUS_EDGE_TRACKER_ASSERT_SVH
`define JOB_STATUS_EDGE_TRACKER_ASSERT_SVH

// Same-cycle implication, clocked on clk and quiet during rst
`define JSET_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("job status edge tracker: check failed");

// Next-cycle implication, clocked on clk and quiet during rst
`define JSET_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("job status edge tracker: check failed");

`endif

// ===== sv/jset_pkg.sv =====
// Shared types, constants and functions of the job status edge tracker.
package jset_pkg;

  localparam int ENTRIES = 12;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam logic [2:0] ST_OFFLINE        = 3'd0;
  localparam logic [2:0] ST_IDLE           = 3'd1;
  localparam logic [2:0] ST_RUNNING        = 3'd2;
  localparam logic [2:0] ST_DONE           = 3'd3;
  localparam logic [2:0] ST_ERROR          = 3'd4;
  localparam logic [2:0] ST_WAIT_INPUT     = 3'd5;
  localparam logic [2:0] ST_AWAIT_APPROVAL = 3'd6;
  localparam logic [2:0] ST_OTHER          = 3'd7;

  localparam logic [1:0] SND_NONE  = 2'd0;
  localparam logic [1:0] SND_DONE  = 2'd1;
  localparam logic [1:0] SND_ERROR = 2'd2;
  localparam logic [1:0] SND_NEEDS = 2'd3;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic [31:0] job_key;
    logic [2:0]  job_status;
  } req_t;

  typedef struct packed {
    logic       is_edge;
    logic [1:0] sound_code;
  } result_t;

  typedef logic [ENTRIES-1:0][31:0] key_array_t;
  typedef logic [ENTRIES-1:0]       used_array_t;

  typedef struct packed {
    logic hit;
    idx_t hit_idx;
    logic free_found;
    idx_t free_idx;
  } lookup_t;

  // Map a status to the sound that an edge into it raises
  function automatic logic [1:0] sound_for(input logic [2:0] status);
    logic [1:0] snd;
    unique case (status) inside
      ST_DONE:                          snd = SND_DONE;
      ST_ERROR:                         snd = SND_ERROR;
      ST_WAIT_INPUT, ST_AWAIT_APPROVAL: snd = SND_NEEDS;
      default:                          snd = SND_NONE;
    endcase
    return snd;
  endfunction

endpackage

// ===== sv/jset_lookup.sv =====
// Parallel key compare and lowest-free-entry pick over the job table.
module jset_lookup (
  input  logic [31:0]          key,
  input  jset_pkg::key_array_t keys,
  input  jset_pkg::used_array_t used,
  output jset_pkg::lookup_t    lookup
);

  // Scan from the top down so the lowest matching and lowest free entry win
  always_comb begin
    lookup = '0;
    for (int i = jset_pkg::ENTRIES - 1; i >= 0; i--) begin
      if (used[i] && (keys[i] == key)) begin
        lookup.hit     = 1'b1;
        lookup.hit_idx = jset_pkg::IDX_W'(i);
      end
      if (!used[i]) begin
        lookup.free_found = 1'b1;
        lookup.free_idx   = jset_pkg::IDX_W'(i);
      end
    end
  end

endmodule

// ===== sv/jset_table.sv =====
// Job table storage, update decision and round-robin eviction pointer.
module jset_table (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  input  jset_pkg::req_t        item,
  input  jset_pkg::lookup_t     lookup,
  output jset_pkg::key_array_t  keys,
  output jset_pkg::used_array_t used,
  output jset_pkg::result_t     decision
);

  logic [jset_pkg::ENTRIES-1:0][2:0] status;
  logic [jset_pkg::ENTRIES-1:0][2:0] status_next;
  jset_pkg::key_array_t              keys_next;
  jset_pkg::used_array_t             used_next;
  jset_pkg::idx_t                    ptr;
  jset_pkg::idx_t                    ptr_next;
  jset_pkg::idx_t                    slot;

  // Decide the table update and the result for the request in flight
  always_comb begin
    keys_next   = keys;
    status_next = status;
    used_next   = used;
    ptr_next    = ptr;
    decision    = '0;
    slot        = lookup.hit ? lookup.hit_idx :
                  (lookup.free_found ? lookup.free_idx : ptr);
    if (item_valid) begin
      if (item.job_status == jset_pkg::ST_OFFLINE) begin
        // Drop a live job; unknown keys are ignored
        if (lookup.hit) begin
          used_next[lookup.hit_idx] = 1'b0;
          decision.is_edge          = 1'b1;
        end
      end else if (!(lookup.hit && (status[lookup.hit_idx] == item.job_status))) begin
        if (!lookup.hit) begin
          // Advance the eviction pointer only when the table is full
          if (!lookup.free_found) begin
            ptr_next = (ptr == jset_pkg::IDX_W'(jset_pkg::ENTRIES - 1)) ?
                       '0 : ptr + jset_pkg::IDX_W'(1);
          end
          used_next[slot] = 1'b1;
          keys_next[slot] = item.job_key;
        end
        status_next[slot]   = item.job_status;
        decision.is_edge    = 1'b1;
        decision.sound_code = jset_pkg::sound_for(item.job_status);
      end
    end
  end

  // Hold keys and statuses; they are read only where the used bit is set
  always_ff @(posedge clk) begin
    keys   <= keys_next;
    status <= status_next;
  end

  // Clear the used bits and pointer on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      ptr  <= '0;
    end else begin
      used <= used_next;
      ptr  <= ptr_next;
    end
  end

endmodule

// ===== sv/job_status_edge_tracker.sv =====
// Top level of the job status edge tracker: request register, table, result register.
//
//   channel  | handshake      | payload
//   request  | start, busy    | req    (job_key, job_status)
//   result   | valid (strobe) | result (is_edge, sound_code)
//
// One request is taken every cycle while busy is low; the result strobes from the result register,
// which follows the request register. The table lookup, free-entry pick and update run
// combinationally between the request register and the result register.
// Reset clears the used bits, the eviction pointer and both valid flags; busy is
// high only while rst is asserted. The receiver cannot stall the result strobe.
`include "job_status_edge_tracker_assert.svh"

module job_status_edge_tracker (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  jset_pkg::req_t      req,
  output logic                valid,
  output jset_pkg::result_t   result
);

  logic                  in_valid;
  jset_pkg::req_t        in_req;
  jset_pkg::lookup_t     lookup;
  jset_pkg::key_array_t  keys;
  jset_pkg::used_array_t used;
  jset_pkg::result_t     decision;

  assign busy = rst;

  // Capture an accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_req <= req;
    end
  end

  jset_lookup u_lookup (
    .key    (in_req.job_key),
    .keys   (keys),
    .used   (used),
    .lookup (lookup)
  );

  jset_table u_table (
    .clk        (clk),
    .rst        (rst),
    .item_valid (in_valid),
    .item       (in_req),
    .lookup     (lookup),
    .keys       (keys),
    .used       (used),
    .decision   (decision)
  );

  // Register the result and its one-cycle strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    result <= decision;
  end

  `JSET_ASSERT_NEXT(a_result_follows, in_valid, valid)
  `JSET_ASSERT_NEXT(a_no_spurious_result, !in_valid, !valid)
  `JSET_ASSERT_NOW(a_sound_needs_edge, valid && (result.sound_code != jset_pkg::SND_NONE), result.is_edge)

endmodule
